// ----- hw/rtl/csc_pkg.sv -----
package csc_pkg;

    // Conversion codes held in the mode register
    localparam logic [2:0] MODE_RGB_HSL = 3'd0;
    localparam logic [2:0] MODE_HSL_HSV = 3'd1;
    localparam logic [2:0] MODE_HSV_RGB = 3'd2;
    localparam logic [2:0] MODE_RGB_HSV = 3'd3;
    localparam logic [2:0] MODE_HSV_HSL = 3'd4;
    localparam logic [2:0] MODE_HSL_RGB = 3'd5;

    // Common denominator of the HSV-to-RGB and HSL-to-RGB channel formulas
    localparam logic [22:0] DEN_FULL = 23'd2304000;

    // Number of quotient bits, one divider cell per bit
    localparam int QUO_BITS = 8;

    // One component before division: num = mul_a * mul_b + addend, over den
    typedef struct packed {
        logic signed [27:0] mul_a;
        logic signed [15:0] mul_b;
        logic signed [35:0] addend;
        logic [22:0]        den;
    } t_term;

    typedef struct packed {
        logic        valid;
        logic [7:0]  alpha;
        t_term [2:0] term;
    } t_front_bus;

    // One component inside the divider chain
    typedef struct packed {
        logic [31:0] rem;
        logic [23:0] div;
        logic        force_zero;
        logic        force_sat;
        logic [7:0]  quo;
    } t_div_lane;

    typedef struct packed {
        logic            valid;
        logic [7:0]      alpha;
        t_div_lane [2:0] lane;
    } t_cell_bus;

    // Term that rounds to a plain value or ratio, no product
    function automatic t_term term_ratio(input logic signed [35:0] num,
                                         input logic [22:0] den);
        t_term t;
        t.mul_a  = '0;
        t.mul_b  = '0;
        t.addend = num;
        t.den    = den;
        return t;
    endfunction

endpackage

// ----- hw/rtl/csc_src_if.sv -----
interface csc_src_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_word;

    modport source (output valid, output source_word, input ready);
    modport sink   (input valid, input source_word, output ready);
endinterface

// ----- hw/rtl/csc_dst_if.sv -----
interface csc_dst_if;
    logic        valid;
    logic        ready;
    logic [31:0] converted_word;

    modport source (output valid, output converted_word, input ready);
    modport sink   (input valid, input converted_word, output ready);
endinterface

// ----- hw/rtl/csc_front.sv -----
module csc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_word,
    input  logic [2:0]            i_mode,
    output csc_pkg::t_front_bus   o_bus
);

    // Stage 1 inputs
    logic [7:0]         s_a, s_b, s_c, s_mx, s_mn, s_d;
    logic signed [17:0] s_sa, s_sb, s_sc, s_sd, s_hue_raw, s_hue;
    logic [2:0]         s_sect;
    logic [5:0]         s_f;

    // Stage 1 registers
    logic               r_s1_valid;
    logic [2:0]         r_mode;
    logic [7:0]         r_alpha, r_a, r_b, r_c, r_mx, r_mn, r_d;
    logic signed [17:0] r_hue;
    logic [2:0]         r_sect;
    logic [13:0]        r_fb;
    logic [15:0]        r_bc;
    logic [16:0]        r_cqb;
    logic signed [18:0] r_t1;
    logic [16:0]        r_k;

    // Stage 2 logic
    logic [8:0]         mm_sum;
    logic [16:0]        v240;
    logic signed [19:0] q5, p5;
    logic signed [20:0] qp5;
    logic signed [27:0] qp255;
    logic signed [15:0] m1, m2, m3, m4;
    logic signed [15:0] m_sel [3];
    logic signed [27:0] c255;
    logic signed [17:0] den4;
    logic signed [9:0]  t_raw [3];
    logic [7:0]         t_wrap [3];
    csc_pkg::t_term     n_term [3];
    csc_pkg::t_front_bus r_bus;

    // Max, min and hue of the source components
    assign s_a = i_word[23:16];
    assign s_b = i_word[15:8];
    assign s_c = i_word[7:0];

    always_comb begin
        s_mx = (s_a > s_b) ? s_a : s_b;
        if (s_c > s_mx) s_mx = s_c;
        s_mn = (s_a < s_b) ? s_a : s_b;
        if (s_c < s_mn) s_mn = s_c;
        s_d  = s_mx - s_mn;
        s_sa = $signed({10'd0, s_a});
        s_sb = $signed({10'd0, s_b});
        s_sc = $signed({10'd0, s_c});
        s_sd = $signed({10'd0, s_d});
        if (s_mx == s_a) begin
            s_hue_raw = 18'(40 * (s_sb - s_sc));
        end else if (s_mx == s_b) begin
            s_hue_raw = 18'(40 * (s_sc - s_sa) + 80 * s_sd);
        end else begin
            s_hue_raw = 18'(40 * (s_sa - s_sb) + 160 * s_sd);
        end
        s_hue = (s_hue_raw < 0) ? 18'(s_hue_raw + 240 * s_sd) : s_hue_raw;
    end

    // Hue sector and offset for HSV to RGB
    always_comb begin
        s_sect = {2'd0, s_a >= 8'd40} + {2'd0, s_a >= 8'd80} + {2'd0, s_a >= 8'd120}
               + {2'd0, s_a >= 8'd160} + {2'd0, s_a >= 8'd200};
        s_f    = 6'(s_a - 8'(40 * s_sect));
    end

    // Capture stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode  <= i_mode;
            r_alpha <= i_word[31:24];
            r_a     <= s_a;
            r_b     <= s_b;
            r_c     <= s_c;
            r_mx    <= s_mx;
            r_mn    <= s_mn;
            r_d     <= s_d;
            r_hue   <= s_hue;
            r_sect  <= s_sect;
            r_fb    <= s_f * s_b;
            r_bc    <= s_b * s_c;
            r_cqb   <= s_c * (9'd240 + {1'b0, s_b});
            r_t1    <= $signed({1'b0, s_b}) * $signed(10'd480 - {1'b0, s_c, 1'b0});
            r_k     <= s_c * (9'd480 - {1'b0, s_b});
        end
    end

    // Shared values for the modes
    always_comb begin
        mm_sum = {1'b0, r_mx} + {1'b0, r_mn};
        v240   = 17'(240 * r_b + 240 * r_c - r_bc);
        q5     = $signed((r_c < 8'd120) ? {3'd0, r_cqb}
                                        : 20'(240 * r_c + 240 * r_b - r_bc));
        p5     = $signed({3'd0, 17'(480 * r_c)}) - q5;
        qp5    = 21'(q5) - 21'(p5);
        qp255  = 28'(qp5 * 255);
        m1     = 16'sd9600;
        m2     = 16'(40 * (240 - r_b));
        m3     = 16'(9600 - r_fb);
        m4     = 16'(9600 - 40 * r_b + r_fb);
        c255   = $signed({12'd0, 16'(r_c * 255)});
        den4   = $signed(18'(115200 - r_k));
        t_raw[0] = $signed({2'd0, r_a}) + 10'sd80;
        t_raw[1] = $signed({2'd0, r_a});
        t_raw[2] = $signed({2'd0, r_a}) - 10'sd80;
        for (int i = 0; i < 3; i++) begin
            if (t_raw[i] < 0) begin
                t_wrap[i] = 8'(t_raw[i] + 10'sd240);
            end else if (t_raw[i] > 10'sd240) begin
                t_wrap[i] = 8'(t_raw[i] - 10'sd240);
            end else begin
                t_wrap[i] = t_raw[i][7:0];
            end
        end
        case (r_sect)
            3'd0: begin m_sel[0] = m1; m_sel[1] = m4; m_sel[2] = m2; end
            3'd1: begin m_sel[0] = m3; m_sel[1] = m1; m_sel[2] = m2; end
            3'd2: begin m_sel[0] = m2; m_sel[1] = m1; m_sel[2] = m4; end
            3'd3: begin m_sel[0] = m2; m_sel[1] = m3; m_sel[2] = m1; end
            3'd4: begin m_sel[0] = m4; m_sel[1] = m2; m_sel[2] = m1; end
            default: begin m_sel[0] = m1; m_sel[1] = m2; m_sel[2] = m3; end
        endcase
    end

    // Build numerator and denominator of each output component
    always_comb begin
        n_term[0] = csc_pkg::term_ratio(36'(r_a), 23'd1);
        n_term[1] = csc_pkg::term_ratio(36'(r_b), 23'd1);
        n_term[2] = csc_pkg::term_ratio(36'(r_c), 23'd1);
        case (r_mode)
            csc_pkg::MODE_RGB_HSL, csc_pkg::MODE_RGB_HSV: begin
                if (r_mode == csc_pkg::MODE_RGB_HSL) begin
                    n_term[2] = csc_pkg::term_ratio(36'(mm_sum * 120), 23'd255);
                end else begin
                    n_term[2] = csc_pkg::term_ratio(36'(r_mx * 240), 23'd255);
                end
                if (r_d == 8'd0) begin
                    n_term[0] = csc_pkg::term_ratio('0, 23'd1);
                    n_term[1] = csc_pkg::term_ratio('0, 23'd1);
                end else begin
                    n_term[0] = csc_pkg::term_ratio(36'(r_hue), 23'(r_d));
                    if (r_mode == csc_pkg::MODE_RGB_HSV) begin
                        n_term[1] = csc_pkg::term_ratio(36'(r_d * 240), 23'(r_mx));
                    end else if (mm_sum < 9'd255) begin
                        n_term[1] = csc_pkg::term_ratio(36'(r_d * 240), 23'(mm_sum));
                    end else begin
                        n_term[1] = csc_pkg::term_ratio(36'(r_d * 240),
                                                        23'(10'd510 - {1'b0, mm_sum}));
                    end
                end
            end
            csc_pkg::MODE_HSL_HSV: begin
                if (r_c == 8'd0) begin
                    n_term[1] = csc_pkg::term_ratio('0, 23'd1);
                    n_term[2] = csc_pkg::term_ratio('0, 23'd1);
                end else if (r_c <= 8'd120) begin
                    n_term[1] = csc_pkg::term_ratio(36'(480 * r_b), 23'(240 + r_b));
                    n_term[2] = csc_pkg::term_ratio(36'(r_cqb), 23'd240);
                end else begin
                    n_term[1] = csc_pkg::term_ratio(36'(r_t1 * 240), 23'(v240));
                    n_term[2] = csc_pkg::term_ratio(36'(v240), 23'd240);
                end
            end
            csc_pkg::MODE_HSV_RGB: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_a >= 8'd240) begin
                        n_term[i] = csc_pkg::term_ratio('0, 23'd1);
                    end else begin
                        n_term[i].mul_a  = c255;
                        n_term[i].mul_b  = m_sel[i];
                        n_term[i].addend = '0;
                        n_term[i].den    = csc_pkg::DEN_FULL;
                    end
                end
            end
            csc_pkg::MODE_HSV_HSL: begin
                if (r_c == 8'd0) begin
                    n_term[1] = csc_pkg::term_ratio('0, 23'd1);
                    n_term[2] = csc_pkg::term_ratio('0, 23'd1);
                end else begin
                    n_term[2] = csc_pkg::term_ratio(36'(r_k), 23'd480);
                    if (r_k <= 17'd57600) begin
                        n_term[1] = csc_pkg::term_ratio(36'(240 * r_b), 23'(480 - r_b));
                    end else if (den4 > 0) begin
                        n_term[1] = csc_pkg::term_ratio(36'(240 * r_bc), 23'(den4));
                    end else begin
                        n_term[1] = csc_pkg::term_ratio('0, 23'd1);
                    end
                end
            end
            csc_pkg::MODE_HSL_RGB: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_b == 8'd0) begin
                        n_term[i] = csc_pkg::term_ratio(36'(r_c * 255), 23'd240);
                    end else begin
                        n_term[i].mul_a  = '0;
                        n_term[i].mul_b  = '0;
                        n_term[i].addend = 36'(10200 * p5);
                        n_term[i].den    = csc_pkg::DEN_FULL;
                        if (t_wrap[i] < 8'd40) begin
                            n_term[i].mul_a = qp255;
                            n_term[i].mul_b = $signed({8'd0, t_wrap[i]});
                        end else if (t_wrap[i] < 8'd120) begin
                            n_term[i].addend = 36'(10200 * q5);
                        end else if (t_wrap[i] < 8'd160) begin
                            n_term[i].mul_a = qp255;
                            n_term[i].mul_b = $signed({8'd0, 8'd160 - t_wrap[i]});
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Capture stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus.valid   <= r_s1_valid;
            r_bus.alpha   <= r_alpha;
            r_bus.term[0] <= n_term[0];
            r_bus.term[1] <= n_term[1];
            r_bus.term[2] <= n_term[2];
        end
    end

    assign o_bus = r_bus;

endmodule

// ----- hw/rtl/csc_scale.sv -----
module csc_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  csc_pkg::t_front_bus i_bus,
    output csc_pkg::t_cell_bus  o_bus
);

    logic               r_valid;
    logic [7:0]         r_alpha;
    logic signed [35:0] r_num [3];
    logic [22:0]        r_den [3];
    logic signed [43:0] prod [3];
    logic signed [37:0] x [3];
    logic [23:0]        y [3];
    csc_pkg::t_cell_bus n_bus, r_bus;

    // Form the full numerator with the one product of each component
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = i_bus.term[i].mul_a * i_bus.term[i].mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_alpha <= i_bus.alpha;
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= prod[i][35:0] + i_bus.term[i].addend;
                r_den[i] <= i_bus.term[i].den;
            end
        end
    end

    // Round half up: floor((2n + d) / 2d), flag negative and overflow
    always_comb begin
        n_bus.valid = r_valid;
        n_bus.alpha = r_alpha;
        for (int i = 0; i < 3; i++) begin
            x[i] = $signed({r_num[i][35], r_num[i], 1'b0}) + $signed({15'd0, r_den[i]});
            y[i] = {r_den[i], 1'b0};
            n_bus.lane[i].rem        = x[i][31:0];
            n_bus.lane[i].div        = y[i];
            n_bus.lane[i].force_zero = x[i][37];
            n_bus.lane[i].force_sat  = !x[i][37] && (x[i][36:0] >= {5'd0, y[i], 8'd0});
            n_bus.lane[i].quo        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ----- hw/rtl/csc_div_cell.sv -----
module csc_div_cell #(
    parameter int BIT = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  csc_pkg::t_cell_bus i_bus,
    output csc_pkg::t_cell_bus o_bus
);

    logic [31:0]        shifted [3];
    csc_pkg::t_cell_bus n_bus, r_bus;

    // Decide one quotient bit per component: compare and subtract
    always_comb begin
        n_bus = i_bus;
        for (int i = 0; i < 3; i++) begin
            shifted[i] = 32'(i_bus.lane[i].div) << BIT;
            if (i_bus.lane[i].rem >= shifted[i]) begin
                n_bus.lane[i].rem      = i_bus.lane[i].rem - shifted[i];
                n_bus.lane[i].quo[BIT] = 1'b1;
            end
        end
    end

    // Hand the partial result to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ----- hw/rtl/color_space_converter_core.sv -----
// Color space converter: one packed pixel in, one converted pixel out.
// Input channel i_src carries source_word (alpha in bits 31..24, three
// components below); output channel o_dst carries converted_word with
// alpha unchanged. A transfer happens when valid and ready are both high.
// i_cfg_we / i_cfg_wdata write the 3-bit conversion mode; change it only
// while no pixel is in flight.
// The pipeline has 12 register stages: two front stages form numerator and
// denominator per component, two stages do the product and rounding setup,
// and a chain of eight divider cells yields one quotient bit each. A pixel
// passes through these stages in order before it shows valid at the
// output. Throughput is one pixel per cycle while the output does not stall.
// The whole pipeline advances together: when the receiver holds ready low
// with a result waiting, every stage holds and i_src.ready drops; empty
// output lets the pipeline refill at full rate.
// Synchronous reset clears all valid flags and sets the mode to RGB to HSL.
module color_space_converter_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    csc_src_if.sink          i_src,
    csc_dst_if.source        o_dst,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_wdata
);

    logic [2:0]            r_cfg_mode;
    logic                  en;
    csc_pkg::t_front_bus   front_bus;
    csc_pkg::t_cell_bus    chain [csc_pkg::QUO_BITS + 1];
    csc_pkg::t_cell_bus    last_bus;
    logic [7:0]            comp [3];

    // Hold the conversion mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode <= csc_pkg::MODE_RGB_HSL;
        end else if (i_cfg_we) begin
            r_cfg_mode <= i_cfg_wdata;
        end
    end

    // Advance everything unless a waiting result is stalled
    assign en          = !last_bus.valid || o_dst.ready;
    assign i_src.ready = en;

    csc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_src.valid),
        .i_word  (i_src.source_word),
        .i_mode  (r_cfg_mode),
        .o_bus   (front_bus)
    );

    csc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_bus   (front_bus),
        .o_bus   (chain[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar g = 0; g < csc_pkg::QUO_BITS; g++) begin : g_cell
        csc_div_cell #(
            .BIT (csc_pkg::QUO_BITS - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (chain[g]),
            .o_bus   (chain[g + 1])
        );
    end

    assign last_bus = chain[csc_pkg::QUO_BITS];

    // Apply saturation and the negative clamp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (last_bus.lane[i].force_zero) begin
                comp[i] = 8'd0;
            end else if (last_bus.lane[i].force_sat) begin
                comp[i] = 8'd255;
            end else begin
                comp[i] = last_bus.lane[i].quo;
            end
        end
    end

    assign o_dst.valid          = last_bus.valid;
    assign o_dst.converted_word = {last_bus.alpha, comp[0], comp[1], comp[2]};

endmodule

// ----- hw/rtl/csc_checker.sv -----
module csc_protocol_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_word)))
        else $error("stalled output changed");

    // An empty output stage never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // A draining receiver never blocks input
    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input blocked while output drains");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind color_space_converter_core csc_protocol_checker u_csc_protocol_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_src.valid),
    .i_in_ready  (i_src.ready),
    .i_out_valid (o_dst.valid),
    .i_out_ready (o_dst.ready),
    .i_out_word  (o_dst.converted_word)
);
